/* hdl/rpc_pkg.sv */
// Shared types, constants and tables for the rectangular/polar converter.
package rpc_pkg;

  localparam int GUARD = 8;
  localparam int CW    = 44;   // CORDIC x/y width: 33-bit magnitude plus guard and growth
  localparam int ZW    = 36;   // CORDIC angle width, radians Q30

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] DEG2RAD_Q36  = 32'd1199381129;

  typedef enum logic [1:0] {
    FORM_RECT  = 2'd0,
    FORM_POLAR = 2'd1,
    FORM_ZERO  = 2'd2
  } form_t;

  typedef struct packed {
    form_t              form;
    logic               zero_vec;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } front_item_t;

  typedef struct packed {
    form_t                  form;
    logic                   zero_vec;
    logic signed [31:0]     first_value;
    logic signed [31:0]     second_value;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic signed [31:0]     angle_rad;
  } stage_t;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [32:0] magnitude;
    logic signed [31:0] angle_rad;
    logic               form_out;
  } result_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] t [32];
    t = '{32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
          32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
          32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
          32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
          32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0};
    return t[i[4:0]];
  endfunction

endpackage

/* hdl/rpc_if.sv */
// Valid/ready stream interface used by the converter channels.
interface rpc_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rpc_front.sv */
// Front end: accept beats, classify the form code and feed a two-entry queue.
module rpc_front
  import rpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_form,
  input  logic [31:0] in_first_value,
  input  logic [31:0] in_second_value,
  output logic        q_valid,
  input  logic        q_ready,
  output front_item_t q_item
);
  front_item_t mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  front_item_t cls;
  logic        push, pop;

  always_comb begin
    case (in_form)
      FORM_RECT:  cls.form = FORM_RECT;
      FORM_POLAR: cls.form = FORM_POLAR;
      default:    cls.form = FORM_ZERO;
    endcase
    cls.zero_vec     = (in_first_value == '0) && (in_second_value == '0);
    cls.first_value  = in_first_value;
    cls.second_value = in_second_value;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule

/* hdl/rpc_back.sv */
// Back end: pipelined CORDIC with set-up, rotation and finishing stages.
module rpc_back
  import rpc_pkg::*;
#(
  parameter int ITERATIONS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  front_item_t q_item,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);
  // pipeline: P0 reduction and deg-to-rad product, P1 reduced-angle product,
  // P2 pre-scale, P3 set-up, one stage per iteration, gain product, then round
  localparam int NS = ITERATIONS + 5;

  logic   vld_r [NS];
  stage_t st_r  [NS];
  logic   adv;

  // skid-free output register; pipeline stalls as a whole when it is blocked
  assign adv     = !res_valid || res_ready;
  assign q_ready = adv;

  // stage 0: capture and form degree products
  localparam int RSH = FRAC_BITS + 3;   // a full turn, 360 << FRAC_BITS, is 45 << RSH
  localparam int HW  = 32 - RSH;
  localparam logic [26:0] RECIP45 = 27'd95443718;   // ceil(2^32 / 45)

  logic signed [63:0] prod0_r;       // deg * pi/180 for the output angle
  logic signed [31:0] red_deg_r;     // reduced degrees in [-90,90]
  logic               fold0_r;
  logic signed [31:0] red_c;
  logic signed [33:0] full_c, half_c, quart_c, rem_c;
  logic               fold_c;
  logic [26:0]        hp_c, hmod_c;
  logic [53:0]        qprod_c;
  stage_t             s0_c;

  always_comb begin
    full_c  = 34'sd360 <<< FRAC_BITS;
    half_c  = 34'sd180 <<< FRAC_BITS;
    quart_c = 34'sd90  <<< FRAC_BITS;
    // keep the low RSH bits and reduce the rest mod 45; bias it non-negative
    // first so a reciprocal multiply gives the quotient
    hp_c    = {{(27-HW){q_item.second_value[31]}}, q_item.second_value[31:RSH]}
              + (27'd45 << (HW - 1));
    qprod_c = {27'd0, hp_c} * {27'd0, RECIP45};
    hmod_c  = hp_c - {5'd0, qprod_c[53:32]} * 27'd45;
    rem_c   = $signed({{(28-RSH){1'b0}}, hmod_c[5:0], q_item.second_value[RSH-1:0]});
    if (rem_c > half_c) rem_c = rem_c - full_c;
    fold_c = 1'b0;
    if (rem_c > quart_c) begin
      rem_c  = rem_c - half_c;
      fold_c = 1'b1;
    end else if (rem_c < -quart_c) begin
      rem_c  = rem_c + half_c;
      fold_c = 1'b1;
    end
    red_c = rem_c[31:0];
  end

  always_comb begin
    s0_c              = '0;
    s0_c.form         = q_item.form;
    s0_c.zero_vec     = q_item.zero_vec;
    s0_c.first_value  = q_item.first_value;
    s0_c.second_value = q_item.second_value;
  end

  // stage 1 products
  logic signed [63:0] zprod_r;
  // stage 2 magnitude scaling
  logic [63:0]        mscale_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]   <= s0_c;
      prod0_r   <= q_item.second_value * $signed({1'b0, DEG2RAD_Q36});
      red_deg_r <= red_c;
      fold0_r   <= fold_c;
    end
  end

  // stage 1: round output angle, reduced-angle product
  logic signed [64:0] ar_c;
  logic signed [31:0] ang_sat_c;
  stage_t             s1_c;
  always_comb begin
    ar_c = ($signed({prod0_r[63], prod0_r}) + (65'sd1 <<< 35)) >>> 36;
    if (ar_c > 65'sd2147483647) ang_sat_c = 32'sh7fffffff;
    else if (ar_c < -65'sd2147483648) ang_sat_c = 32'sh80000000;
    else ang_sat_c = ar_c[31:0];
    s1_c           = st_r[0];
    s1_c.angle_rad = ang_sat_c;
  end
  logic fold1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[1] <= s1_c;
      zprod_r <= red_deg_r * $signed({1'b0, DEG2RAD_Q36});
      fold1_r <= fold0_r;
    end
  end

  // stage 2: z start and magnitude pre-scale product
  logic [31:0] mabs_c;
  logic        neg2_c;
  logic signed [ZW-1:0] zpol_c;
  logic signed [63:0]   zr_c;
  logic        neg2_r;
  logic signed [ZW-1:0] zpol_r;
  always_comb begin
    mabs_c = st_r[1].first_value[31] ? 32'(-st_r[1].first_value) : st_r[1].first_value;
    neg2_c = st_r[1].first_value[31] ^ fold1_r;
    zr_c   = (zprod_r + (64'sd1 <<< (FRAC_BITS + 5))) >>> (FRAC_BITS + 6);
    zpol_c = zr_c[ZW-1:0];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[2]  <= st_r[1];
      mscale_r <= {32'd0, mabs_c} * {32'd0, INV_GAIN_Q30};
      neg2_r   <= neg2_c;
      zpol_r   <= zpol_c;
    end
  end

  // stage 3: initial CORDIC vector
  logic [63:0] xs_c;
  logic signed [CW-1:0] x0_c, y0_c;
  logic signed [ZW-1:0] z0_c;
  stage_t               s3_c;
  always_comb begin
    // round(|m|<<8 * g / 2^30), taken as round(|m| * g / 2^22) to stay in 64 bits
    xs_c = (mscale_r + (64'd1 << 21)) >> 22;
    x0_c = '0;
    y0_c = '0;
    z0_c = '0;
    if (st_r[2].form == FORM_POLAR) begin
      x0_c = neg2_r ? -$signed({1'b0, xs_c[CW-2:0]}) : $signed({1'b0, xs_c[CW-2:0]});
      z0_c = zpol_r;
    end else begin
      x0_c = CW'(st_r[2].first_value) <<< GUARD;
      y0_c = CW'(st_r[2].second_value) <<< GUARD;
      x0_c = $signed({{(CW-32){st_r[2].first_value[31]}}, st_r[2].first_value}) <<< GUARD;
      y0_c = $signed({{(CW-32){st_r[2].second_value[31]}}, st_r[2].second_value}) <<< GUARD;
      if (st_r[2].first_value[31]) begin
        z0_c = st_r[2].second_value[31] ? -$signed({4'd0, PI_Q30}) : $signed({4'd0, PI_Q30});
        x0_c = -x0_c;
        y0_c = -y0_c;
      end
    end
    s3_c   = st_r[2];
    s3_c.x = x0_c;
    s3_c.y = y0_c;
    s3_c.z = z0_c;
  end
  always_ff @(posedge clk) begin
    if (adv) st_r[3] <= s3_c;
  end

  // CORDIC iterations, one per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_it
    stage_t cur, nxt;
    logic   dpos;
    logic signed [ZW-1:0] at;
    always_comb begin
      cur  = st_r[3+i];
      nxt  = cur;
      at   = $signed({4'd0, atan_q30(i)});
      dpos = (cur.form == FORM_POLAR) ? !cur.z[ZW-1] : !cur.y[CW-1];
      if (cur.form == FORM_POLAR) begin
        if (dpos) begin
          nxt.x = cur.x - (cur.y >>> i); nxt.y = cur.y + (cur.x >>> i); nxt.z = cur.z - at;
        end else begin
          nxt.x = cur.x + (cur.y >>> i); nxt.y = cur.y - (cur.x >>> i); nxt.z = cur.z + at;
        end
      end else begin
        if (dpos) begin
          nxt.x = cur.x + (cur.y >>> i); nxt.y = cur.y - (cur.x >>> i); nxt.z = cur.z + at;
        end else begin
          nxt.x = cur.x - (cur.y >>> i); nxt.y = cur.y + (cur.x >>> i); nxt.z = cur.z - at;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st_r[4+i] <= nxt;
    end
  end

  // stage ITERATIONS+4: gain correction product for the magnitude
  localparam int SF = ITERATIONS + 3;
  logic [CW-1:0] xpos_c;
  logic [63:0]   hi_r, lo_r;
  always_comb begin
    xpos_c = st_r[SF].x[CW-1] ? '0 : st_r[SF].x;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[SF+1] <= st_r[SF];
      hi_r <= 64'(xpos_c >> 21) * {32'd0, INV_GAIN_Q30};
      lo_r <= {43'd0, xpos_c[20:0]} * {32'd0, INV_GAIN_Q30};
    end
  end

  // final stage: round, saturate, select per form
  logic [63:0] t_c, m_c;
  logic signed [CW-1:0] xr_c, yr_c;
  logic signed [ZW-1:0] zr2_c;
  result_t r_c;
  stage_t  f;
  function automatic logic signed [31:0] sat(input logic signed [CW-1:0] v);
    if (v > $signed(CW'(32'h7fffffff))) return 32'sh7fffffff;
    if (v < -$signed(CW'(33'h080000000))) return 32'sh80000000;
    return v[31:0];
  endfunction
  always_comb begin
    f     = st_r[SF+1];
    t_c   = hi_r + (lo_r >> 21);
    m_c   = (t_c + (64'd1 << (30 + GUARD - 22))) >> (30 + GUARD - 21);
    xr_c  = (f.x + (CW'(1) <<< (GUARD - 1))) >>> GUARD;
    yr_c  = (f.y + (CW'(1) <<< (GUARD - 1))) >>> GUARD;
    zr2_c = (f.z + (ZW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    r_c   = '0;
    case (f.form)
      FORM_RECT: begin
        r_c.x_coord = f.first_value;
        r_c.y_coord = f.second_value;
        if (!f.zero_vec) begin
          r_c.magnitude = (m_c > 64'hffffffff) ? 33'h0ffffffff : {1'b0, m_c[31:0]};
          r_c.angle_rad = zr2_c[31:0];
        end
      end
      FORM_POLAR: begin
        r_c.form_out  = 1'b1;
        r_c.magnitude = {f.first_value[31], f.first_value};
        r_c.angle_rad = f.angle_rad;
        r_c.x_coord   = sat(xr_c);
        r_c.y_coord   = sat(yr_c);
      end
      default: r_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) res <= r_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
      res_valid <= vld_r[SF+1];
    end
  end
endmodule

/* hdl/rect_polar_converter_core.sv */
// Top level of the rectangular/polar CORDIC converter.
// Converts one vector per beat: form 0 (x, y) gives magnitude and atan2 angle in
// radians, form 1 (magnitude, degrees) gives x and y, any other form gives zeros.
// All values are signed Q16.16. A new beat is taken every cycle while the output
// is not blocked; each beat passes through the two-entry input queue and then
// the one-iteration-per-stage CORDIC pipeline. The pipeline advances only when
// the output register is free or being taken; while the result is held, every
// beat in flight waits.
module rect_polar_converter_core
  import rpc_pkg::*;
#(
  parameter int ITERATIONS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  rpc_if.sink   in_ch,
  rpc_if.source out_ch
);
  logic        q_valid, q_ready;
  front_item_t q_item;
  result_t     res;

  // front: classify and queue
  rpc_front u_front (
    .clk, .rst_n,
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_form         (in_ch.data[65:64]),
    .in_first_value  (in_ch.data[63:32]),
    .in_second_value (in_ch.data[31:0]),
    .q_valid, .q_ready, .q_item
  );

  // back: CORDIC pipeline
  rpc_back #(.ITERATIONS(ITERATIONS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_item,
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res
  );

  assign out_ch.data = res;
endmodule
